// ===== hw/rtl/aob_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aob_pkg
// Shared types and constants for the alpha "over" blend pipeline.
// ----------------------------------------------------------------------------
package aob_pkg;

	localparam int CHAN_W     = 8;             // one color or alpha channel
	localparam int NUM_CH     = 3;             // blue, green, red
	localparam int WGT_W      = 2 * CHAN_W;    // alpha weight, up to 255*255
	localparam int NUM_W      = WGT_W + CHAN_W; // weighted color sum
	localparam int DIV_BITS   = 2;             // quotient bits per divider stage
	localparam int DIV_STAGES = CHAN_W / DIV_BITS;

	localparam int CH_BLUE  = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_RED   = 2;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [WGT_W-1:0]  wgt_t;
	typedef logic [NUM_W-1:0]  num_t;

	localparam chan_t CHAN_MAX = chan_t'(255);

	// One pixel pair as it enters the pipeline
	typedef struct packed {
		chan_t [NUM_CH-1:0] src;
		chan_t [NUM_CH-1:0] dst;
		chan_t              sa;
		chan_t              da;
	} pix_t;

	// Divider state: partial remainders, and per channel a byte that shifts out
	// dividend bits at the top while quotient bits shift in at the bottom.
	typedef struct packed {
		wgt_t  [NUM_CH-1:0] prem;
		chan_t [NUM_CH-1:0] dig;
		wgt_t               den;
	} div_t;

endpackage

// ===== hw/rtl/aob_pix_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aob_pix_if
// Input channel: one source pixel and one destination pixel per transfer.
// ----------------------------------------------------------------------------
interface aob_pix_if
	import aob_pkg::*;
();
	logic  valid;
	logic  ready;
	chan_t src_blue;
	chan_t src_green;
	chan_t src_red;
	chan_t src_alpha;
	chan_t dst_blue;
	chan_t dst_green;
	chan_t dst_red;
	chan_t dst_alpha;

	modport source (
		output valid, src_blue, src_green, src_red, src_alpha,
		       dst_blue, dst_green, dst_red, dst_alpha,
		input  ready
	);
	modport sink (
		input  valid, src_blue, src_green, src_red, src_alpha,
		       dst_blue, dst_green, dst_red, dst_alpha,
		output ready
	);
endinterface

// ===== hw/rtl/aob_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aob_res_if
// Output channel: one blended pixel per transfer.
// ----------------------------------------------------------------------------
interface aob_res_if
	import aob_pkg::*;
();
	logic  valid;
	logic  ready;
	chan_t out_blue;
	chan_t out_green;
	chan_t out_red;
	chan_t out_alpha;

	modport source (
		output valid, out_blue, out_green, out_red, out_alpha,
		input  ready
	);
	modport sink (
		input  valid, out_blue, out_green, out_red, out_alpha,
		output ready
	);
endinterface

// ===== hw/rtl/alpha_over_blend_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_over_blend_core
// Straight-alpha "over" compositing of a source pixel onto a destination.
//
//   port    dir   fields
//   pixel   sink  src_blue/green/red/alpha, dst_blue/green/red/alpha
//   result  src   out_blue/green/red, out_alpha (always 255)
//
// One pixel per clock while result is not stalled. From the input transfer to
// result.valid a pixel passes three weight/product stages, four divider stages
// of two quotient bits each, then the output register.
// Reset clears only valid bits; no state survives between pixels.
// A stall on result fills the skid entry, which drops pixel.ready on the next
// cycle and freezes the whole pipe; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module alpha_over_blend_core
	import aob_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	aob_pix_if.sink   pixel,
	aob_res_if.source result
);

	logic                     en;
	pix_t                     pix;
	logic [DIV_STAGES:0]      div_valid;
	div_t [DIV_STAGES:0]      div_item;
	chan_t [NUM_CH-1:0]       rgb;
	logic                     den_zero;

	assign pixel.ready = en;

	assign pix.src[CH_BLUE]  = pixel.src_blue;
	assign pix.src[CH_GREEN] = pixel.src_green;
	assign pix.src[CH_RED]   = pixel.src_red;
	assign pix.dst[CH_BLUE]  = pixel.dst_blue;
	assign pix.dst[CH_GREEN] = pixel.dst_green;
	assign pix.dst[CH_RED]   = pixel.dst_red;
	assign pix.sa            = pixel.src_alpha;
	assign pix.da            = pixel.dst_alpha;

	aob_weight u_weight (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (pixel.valid),
		.pix      (pix),
		.valid_s3 (div_valid[0]),
		.item_s3  (div_item[0])
	);

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		aob_div_stage u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid    (div_valid[i]),
			.item     (div_item[i]),
			.valid_s1 (div_valid[i+1]),
			.item_s1  (div_item[i+1])
		);
	end

	// both alphas zero: no weighting, color forced to 0
	assign den_zero = (div_item[DIV_STAGES].den == '0);

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			rgb[c] = den_zero ? '0 : div_item[DIV_STAGES].dig[c];
		end
	end

	aob_skid u_skid (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (div_valid[DIV_STAGES]),
		.rgb    (rgb),
		.ready  (en),
		.res    (result)
	);

endmodule

// ===== hw/rtl/aob_weight.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aob_weight
// Three stages: alpha weights, weighted colors, numerator sum.
// ----------------------------------------------------------------------------
module aob_weight
	import aob_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid,
	input  pix_t pix,
	output logic valid_s3,
	output div_t item_s3
);

	logic                valid_s1, valid_s2;
	wgt_t                ws_s1, wd_s1;
	chan_t [NUM_CH-1:0]  src_s1, dst_s1;
	num_t  [NUM_CH-1:0]  ps_s2, pd_s2;
	wgt_t                den_s2;
	num_t  [NUM_CH-1:0]  num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			num[c] = ps_s2[c] + pd_s2[c];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: ws = sa*255, wd = da*(255-sa)
			ws_s1  <= wgt_t'(pix.sa) * wgt_t'(CHAN_MAX);
			wd_s1  <= wgt_t'(pix.da) * wgt_t'(CHAN_MAX - pix.sa);
			src_s1 <= pix.src;
			dst_s1 <= pix.dst;
			// s2: per-channel products; den never exceeds 255*255
			for (int c = 0; c < NUM_CH; c++) begin
				ps_s2[c] <= num_t'(ws_s1) * num_t'(src_s1[c]);
				pd_s2[c] <= num_t'(wd_s1) * num_t'(dst_s1[c]);
			end
			den_s2 <= ws_s1 + wd_s1;
			// s3: num <= 255*den, so num >> 8 < den and the quotient fits a byte
			for (int c = 0; c < NUM_CH; c++) begin
				item_s3.prem[c] <= num[c][NUM_W-1:CHAN_W];
				item_s3.dig[c]  <= num[c][CHAN_W-1:0];
			end
			item_s3.den <= den_s2;
		end
	end

endmodule

// ===== hw/rtl/aob_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aob_div_stage
// One restoring-division stage: DIV_BITS quotient bits for each channel.
// ----------------------------------------------------------------------------
module aob_div_stage
	import aob_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid,
	input  div_t item,
	output logic valid_s1,
	output div_t item_s1
);

	div_t                nxt;
	logic [WGT_W:0]      trial;
	logic [WGT_W:0]      diff;

	always_comb begin
		nxt   = item;
		trial = '0;
		diff  = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			for (int b = 0; b < DIV_BITS; b++) begin
				trial = {nxt.prem[c], nxt.dig[c][CHAN_W-1]};
				diff  = trial - {1'b0, nxt.den};
				if (!diff[WGT_W]) begin
					nxt.prem[c] = diff[WGT_W-1:0];
					nxt.dig[c]  = {nxt.dig[c][CHAN_W-2:0], 1'b1};
				end else begin
					nxt.prem[c] = trial[WGT_W-1:0];
					nxt.dig[c]  = {nxt.dig[c][CHAN_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= nxt;
		end
	end

endmodule

// ===== hw/rtl/aob_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aob_skid
// Output register plus one skid entry; ready toward the pipe is registered.
// ----------------------------------------------------------------------------
module aob_skid
	import aob_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	input  chan_t [NUM_CH-1:0] rgb,
	output logic               ready,
	aob_res_if.source          res
);

	logic               main_valid_q, skid_valid_q;
	chan_t [NUM_CH-1:0] main_q, skid_q;
	logic               in_xfer, out_xfer;

	assign ready    = !skid_valid_q;
	assign in_xfer  = valid && !skid_valid_q;
	assign out_xfer = main_valid_q && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_xfer) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= in_xfer;
			end
		end else if (in_xfer) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_xfer) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (in_xfer) begin
				main_q <= rgb;
			end
		end else if (in_xfer) begin
			if (main_valid_q) begin
				skid_q <= rgb;
			end else begin
				main_q <= rgb;
			end
		end
	end

	assign res.valid     = main_valid_q;
	assign res.out_blue  = main_q[CH_BLUE];
	assign res.out_green = main_q[CH_GREEN];
	assign res.out_red   = main_q[CH_RED];
	assign res.out_alpha = CHAN_MAX;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks alpha_over_blend_core against a straight-alpha "over" predictor.
// Directed corner pixels first, then random pixel pairs with random idles on
// both channels and a stretch with none; every result is compared in order.
// ----------------------------------------------------------------------------
module testbench;
	import aob_pkg::*;

	localparam int PERIOD_NS    = 10;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 600;
	localparam int IDLE_PCT     = 21;
	localparam int CALM_FIRST   = 250;   // random items without any idling
	localparam int CALM_LAST    = 400;
	localparam int DRAIN_CYCLES = 12;
	localparam int STALL_LIMIT  = 5000;  // cycles without any transfer
	localparam int MAX_PRINTED  = 60;

	typedef struct packed {
		chan_t src_blue;
		chan_t src_green;
		chan_t src_red;
		chan_t src_alpha;
		chan_t dst_blue;
		chan_t dst_green;
		chan_t dst_red;
		chan_t dst_alpha;
	} pixel_pair_t;

	typedef struct packed {
		chan_t blue;
		chan_t green;
		chan_t red;
		chan_t alpha;
	} blended_t;

	class blend_scoreboard;
		blended_t blended_q[$];
		int       error_count;

		function new();
			error_count = 0;
		endfunction

		// exact integer form of the straight-alpha over operator
		static function chan_t blend_chan(chan_t sa, chan_t da, chan_t cs, chan_t cd);
			int unsigned a_s, a_d, c_s, c_d, w_s, w_d, den, num;
			a_s = sa;
			a_d = da;
			c_s = cs;
			c_d = cd;
			w_s = a_s * 255;
			w_d = a_d * (255 - a_s);
			den = w_s + w_d;
			num = w_s * c_s + w_d * c_d;
			if (den == 0)
				return '0;
			return chan_t'(num / den);
		endfunction

		function void note_pixel(pixel_pair_t p);
			blended_t b;
			b.blue  = blend_chan(p.src_alpha, p.dst_alpha, p.src_blue, p.dst_blue);
			b.green = blend_chan(p.src_alpha, p.dst_alpha, p.src_green, p.dst_green);
			b.red   = blend_chan(p.src_alpha, p.dst_alpha, p.src_red, p.dst_red);
			b.alpha = CHAN_MAX;
			blended_q.push_back(b);
		endfunction

		task report_mismatch(string msg);
			error_count++;
			if (error_count <= MAX_PRINTED)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_result(blended_t got);
			blended_t want;
			if (blended_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", got));
				return;
			end
			want = blended_q.pop_front();
			if (got.blue !== want.blue)
				report_mismatch($sformatf("blue %0d, want %0d", got.blue, want.blue));
			if (got.green !== want.green)
				report_mismatch($sformatf("green %0d, want %0d", got.green, want.green));
			if (got.red !== want.red)
				report_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
			if (got.alpha !== want.alpha)
				report_mismatch($sformatf("alpha %0d, want %0d", got.alpha, want.alpha));
		endtask

		function int pending();
			return blended_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic calm;

	aob_pix_if pix_if ();
	aob_res_if res_if ();

	blend_scoreboard sb = new();

	alpha_over_blend_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix_if.sink),
		.result (res_if.source)
	);

	always #(PERIOD_NS / 2) clk = ~clk;

	// result side: stall at random outside the calm stretch
	always @(posedge clk) begin
		if (!arst_n)
			res_if.ready <= 1'b0;
		else
			res_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		pixel_pair_t p;
		if (arst_n && pix_if.valid && pix_if.ready) begin
			p.src_blue  = pix_if.src_blue;
			p.src_green = pix_if.src_green;
			p.src_red   = pix_if.src_red;
			p.src_alpha = pix_if.src_alpha;
			p.dst_blue  = pix_if.dst_blue;
			p.dst_green = pix_if.dst_green;
			p.dst_red   = pix_if.dst_red;
			p.dst_alpha = pix_if.dst_alpha;
			sb.note_pixel(p);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_result({res_if.out_blue, res_if.out_green, res_if.out_red,
				res_if.out_alpha});
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAIL alpha_over_blend_core");
		$finish;
	end

	task automatic send_pixel(input pixel_pair_t p);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			pix_if.valid     <= 1'b0;
			pix_if.src_blue  <= chan_t'($urandom);
			pix_if.dst_alpha <= chan_t'($urandom);
			@(posedge clk);
		end
		pix_if.valid     <= 1'b1;
		pix_if.src_blue  <= p.src_blue;
		pix_if.src_green <= p.src_green;
		pix_if.src_red   <= p.src_red;
		pix_if.src_alpha <= p.src_alpha;
		pix_if.dst_blue  <= p.dst_blue;
		pix_if.dst_green <= p.dst_green;
		pix_if.dst_red   <= p.dst_red;
		pix_if.dst_alpha <= p.dst_alpha;
		@(posedge clk);
		while (!pix_if.ready)
			@(posedge clk);
	endtask

	task automatic send_fields(input int sb_, sg, sr, sa, db, dg, dr, da);
		send_pixel({chan_t'(sb_), chan_t'(sg), chan_t'(sr), chan_t'(sa),
			chan_t'(db), chan_t'(dg), chan_t'(dr), chan_t'(da)});
	endtask

	// alphas lean toward the edges, where the weighting degenerates
	function automatic chan_t pick_alpha();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CHAN_MAX;
			2: return chan_t'(1);
			3: return chan_t'(254);
			4: return chan_t'(128);
			default: return chan_t'($urandom);
		endcase
	endfunction

	initial begin
		pixel_pair_t p;
		arst_n           = 1'b0;
		calm             = 1'b0;
		pix_if.valid     = 1'b0;
		pix_if.src_blue  = '0;
		pix_if.src_green = '0;
		pix_if.src_red   = '0;
		pix_if.src_alpha = '0;
		pix_if.dst_blue  = '0;
		pix_if.dst_green = '0;
		pix_if.dst_red   = '0;
		pix_if.dst_alpha = '0;
		res_if.ready     = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both alphas zero: color forced to 0
		send_fields(255, 255, 255, 0, 255, 255, 255, 0);
		send_fields(0, 0, 0, 0, 0, 0, 0, 0);
		send_fields(170, 85, 1, 0, 85, 170, 254, 0);
		// transparent source shows the destination
		send_fields(255, 255, 255, 0, 12, 200, 99, 255);
		send_fields(0, 0, 0, 0, 255, 128, 1, 1);
		// opaque source covers the destination
		send_fields(33, 144, 250, 255, 255, 0, 7, 0);
		send_fields(0, 255, 128, 255, 255, 0, 127, 255);
		send_fields(255, 255, 255, 255, 255, 255, 255, 255);
		// faint layers and even mixes
		send_fields(255, 0, 255, 1, 0, 255, 0, 0);
		send_fields(255, 0, 128, 1, 0, 255, 127, 255);
		send_fields(255, 255, 255, 128, 0, 0, 0, 128);
		send_fields(0, 0, 0, 128, 255, 255, 255, 128);
		send_fields(255, 0, 255, 254, 0, 255, 0, 1);
		send_fields(0, 255, 0, 254, 255, 0, 255, 255);
		send_fields(1, 254, 127, 127, 254, 1, 128, 128);
		send_fields(255, 255, 255, 1, 255, 255, 255, 1);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= CALM_FIRST) && (i < CALM_LAST);
			p.src_blue  = chan_t'($urandom);
			p.src_green = chan_t'($urandom);
			p.src_red   = chan_t'($urandom);
			p.dst_blue  = chan_t'($urandom);
			p.dst_green = chan_t'($urandom);
			p.dst_red   = chan_t'($urandom);
			p.src_alpha = pick_alpha();
			p.dst_alpha = pick_alpha();
			send_pixel(p);
		end
		calm = 1'b0;
		pix_if.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.error_count == 0)
			$display("PASS alpha_over_blend_core");
		else
			$display("FAIL alpha_over_blend_core");
		$finish;
	end

endmodule
